// ----- src/pvom_pkg.sv -----
// pvom_pkg: shared types and constants for the point voxel occupancy marker
// used by every module of the block; depends on nothing
package pvom_pkg;

	// command codes
	localparam logic CMD_MARK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam int WHOLE_W = 24;   // whole-unit part of a nonnegative offset
	localparam int CSIZE_W = 13;
	localparam int COUNT_W = 6;
	localparam int IDX_W   = 5;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_ORIGIN_Z  = 3'd2,
		REG_CELL_SIZE = 3'd3,
		REG_CELLS_X   = 3'd4,
		REG_CELLS_Y   = 3'd5,
		REG_CELLS_Z   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic              command;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [IDX_W-1:0]  cell_ix;
		logic [IDX_W-1:0]  cell_iy;
		logic [IDX_W-1:0]  cell_iz;
	} in_item_t;

	typedef struct packed {
		logic       was_read;
		logic       occupied;
		logic [3:0] cells_marked;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0]  origin_x;
		logic signed [31:0]  origin_y;
		logic signed [31:0]  origin_z;
		logic [CSIZE_W-1:0]  cell_size;
		logic [COUNT_W-1:0]  cells_x;
		logic [COUNT_W-1:0]  cells_y;
		logic [COUNT_W-1:0]  cells_z;
	} cfg_t;

	// one axis of a classified point
	typedef struct packed {
		logic               neg;
		logic               frac_zero;
		logic [WHOLE_W-1:0] whole;
	} axis_t;

	// queue entry between front and back
	typedef struct packed {
		logic             command;
		axis_t [2:0]      axis;
		logic [IDX_W-1:0] cell_ix;
		logic [IDX_W-1:0] cell_iy;
		logic [IDX_W-1:0] cell_iz;
	} entry_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_HIT,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_READ,
		ST_DONE
	} back_state_t;

endpackage

// ----- src/point_voxel_occupancy_marker_top.sv -----
// point_voxel_occupancy_marker_top: configuration registers and block top
// instantiates pvom_front, pvom_queue and pvom_back; uses pvom_pkg
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  command  | start / busy          | item   (in_item_t)
//  result   | done (strobe)         | result (out_item_t)
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a mark passes, from its transfer to its done strobe on an idle back part, through
// a pop, 24 restoring division steps in three parallel lanes, a hit step,
// four (x, y) pair slots plus one write per matching pair, and a done step;
// a read passes through a pop, one registered memory read and a done step
// after reset busy stays high while the grid is cleared one row per cycle;
// config writes are taken throughout
// busy also rises when the two-entry queue is full; results cannot be stalled
module point_voxel_occupancy_marker_top #(
	parameter int GRID_SIDE = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  pvom_pkg::in_item_t                    item,
	output logic                                  done,
	output pvom_pkg::out_item_t                   result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pvom_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [31:0]                           cfg_data
);
	import pvom_pkg::*;

	cfg_t   cfg_q;
	entry_t fr_entry;
	entry_t q_entry;
	q_ctl_t qc;
	logic   q_empty;
	logic   pop;
	logic   clearing;

	assign cfg_ready = 1'b1;

	// configuration register transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x  <= '0;
			cfg_q.origin_y  <= '0;
			cfg_q.origin_z  <= '0;
			cfg_q.cell_size <= CSIZE_W'(1);
			cfg_q.cells_x   <= COUNT_W'(32);
			cfg_q.cells_y   <= COUNT_W'(32);
			cfg_q.cells_z   <= COUNT_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORIGIN_X:  cfg_q.origin_x  <= cfg_data;
				REG_ORIGIN_Y:  cfg_q.origin_y  <= cfg_data;
				REG_ORIGIN_Z:  cfg_q.origin_z  <= cfg_data;
				REG_CELL_SIZE: cfg_q.cell_size <= cfg_data[CSIZE_W-1:0];
				REG_CELLS_X:   cfg_q.cells_x   <= cfg_data[COUNT_W-1:0];
				REG_CELLS_Y:   cfg_q.cells_y   <= cfg_data[COUNT_W-1:0];
				REG_CELLS_Z:   cfg_q.cells_z   <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	pvom_front u_front (
		.start    (start),
		.clearing (clearing),
		.q_full   (qc.full),
		.item     (item),
		.cfg      (cfg_q),
		.busy     (busy),
		.push     (qc.push),
		.entry    (fr_entry)
	);

	pvom_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (qc.push),
		.wr_entry (fr_entry),
		.pop      (pop),
		.rd_entry (q_entry),
		.empty    (q_empty),
		.full     (qc.full)
	);

	pvom_back #(
		.GRID_SIDE (GRID_SIDE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_entry  (q_entry),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

// ----- src/pvom_front.sv -----
// pvom_front: accepts items and classifies each point axis against the origin
// depends on pvom_pkg
module pvom_front (
	input  logic              start,
	input  logic              clearing,
	input  logic              q_full,
	input  pvom_pkg::in_item_t item,
	input  pvom_pkg::cfg_t    cfg,
	output logic              busy,
	output logic              push,
	output pvom_pkg::entry_t  entry
);
	import pvom_pkg::*;

	logic signed [32:0] d [3];

	// offsets from the grid origin, one wide subtract per axis
	always_comb begin
		d[0] = 33'(item.point_x) - 33'(cfg.origin_x);
		d[1] = 33'(item.point_y) - 33'(cfg.origin_y);
		d[2] = 33'(item.point_z) - 33'(cfg.origin_z);
	end

	// split each offset into sign, whole units and a zero-fraction flag
	always_comb begin
		entry.command = item.command;
		entry.cell_ix = item.cell_ix;
		entry.cell_iy = item.cell_iy;
		entry.cell_iz = item.cell_iz;
		for (int a = 0; a < 3; a++) begin
			entry.axis[a].neg       = d[a][32];
			entry.axis[a].frac_zero = (d[a][7:0] == 8'd0);
			entry.axis[a].whole     = d[a][31:8];
		end
	end

	assign busy = clearing | q_full;
	assign push = start & ~busy;

endmodule

// ----- src/pvom_queue.sv -----
// pvom_queue: two-entry queue between the front and back parts
// depends on pvom_pkg
module pvom_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pvom_pkg::entry_t wr_entry,
	input  logic             pop,
	output pvom_pkg::entry_t rd_entry,
	output logic             empty,
	output logic             full
);
	import pvom_pkg::*;

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_entry;
	end

	assign rd_entry = slot_q[rd_ptr_q];
	assign empty    = (cnt_q == 2'd0);
	assign full     = (cnt_q == 2'd2);

endmodule

// ----- src/pvom_back.sv -----
// pvom_back: divides offsets by the cell size, updates the occupancy rows
// and answers reads; holds the grid memory and its clearing pass; uses pvom_pkg
module pvom_back #(
	parameter int GRID_SIDE = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pvom_pkg::cfg_t      cfg,
	input  logic                q_empty,
	input  pvom_pkg::entry_t    q_entry,
	output logic                pop,
	output logic                clearing,
	output logic                done,
	output pvom_pkg::out_item_t result
);
	import pvom_pkg::*;

	localparam int ROWS = GRID_SIDE * GRID_SIDE;
	localparam int AW   = $clog2(ROWS);
	localparam int IW   = $clog2(GRID_SIDE);
	localparam int NW   = $clog2(GRID_SIDE + 1) > COUNT_W ? $clog2(GRID_SIDE + 1) : COUNT_W;

	back_state_t state_q, state_d;

	// grid memory, one row of z bits per (x, y)
	logic [GRID_SIDE-1:0] mem [ROWS];
	logic [GRID_SIDE-1:0] rd_q;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [GRID_SIDE-1:0] wr_data;

	entry_t               ent_q;
	logic [AW-1:0]        clr_q;
	logic [4:0]           step_q;
	logic [1:0]           pair_q;
	logic [WHOLE_W-1:0]   num_q [3];
	logic [CSIZE_W-1:0]   rem_q [3];
	logic                 hv_q  [3][2];
	logic [IW-1:0]        hi_q  [3][2];
	logic [3:0]           count_q;

	logic [CSIZE_W-1:0]   divisor;
	logic [NW-1:0]        used [3];
	logic [CSIZE_W:0]     sh [3];
	logic                 ge [3];
	logic                 hit_lo [3];
	logic                 hit_hi [3];
	logic [1:0]           nhit [3];
	logic                 pair_ok;
	logic [AW-1:0]        pair_row;
	logic [GRID_SIDE-1:0] zmask;
	logic                 in_range;
	logic [AW-1:0]        read_row;

	assign divisor = (cfg.cell_size == '0) ? CSIZE_W'(1) : cfg.cell_size;

	// cells in use per axis, capped at the grid side
	always_comb begin
		used[0] = (32'(cfg.cells_x) > GRID_SIDE) ? NW'(GRID_SIDE) : NW'(cfg.cells_x);
		used[1] = (32'(cfg.cells_y) > GRID_SIDE) ? NW'(GRID_SIDE) : NW'(cfg.cells_y);
		used[2] = (32'(cfg.cells_z) > GRID_SIDE) ? NW'(GRID_SIDE) : NW'(cfg.cells_z);
	end

	// one restoring division step per lane
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sh[a] = {rem_q[a], num_q[a][WHOLE_W-1]};
			ge[a] = (sh[a] >= {1'b0, divisor});
		end
	end

	// matching cells per axis from quotient and remainder
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			hit_hi[a] = ~ent_q.axis[a].neg && (used[a] != '0)
				&& (num_q[a] < WHOLE_W'(used[a]));
			hit_lo[a] = ~ent_q.axis[a].neg && (used[a] != '0)
				&& ent_q.axis[a].frac_zero && (rem_q[a] == '0)
				&& (num_q[a] != '0) && ((num_q[a] - 1'b1) < WHOLE_W'(used[a]));
			nhit[a] = 2'(hit_lo[a]) + 2'(hit_hi[a]);
		end
	end

	// current (x, y) pair and its z mask
	always_comb begin
		pair_ok  = hv_q[0][pair_q[1]] & hv_q[1][pair_q[0]] & (hv_q[2][0] | hv_q[2][1]);
		pair_row = AW'(32'(hi_q[0][pair_q[1]]) * GRID_SIDE + 32'(hi_q[1][pair_q[0]]));
		zmask    = '0;
		if (hv_q[2][0]) zmask[hi_q[2][0]] = 1'b1;
		if (hv_q[2][1]) zmask[hi_q[2][1]] = 1'b1;
	end

	// read command address and range check
	always_comb begin
		in_range = (32'(ent_q.cell_ix) < GRID_SIDE) && (32'(ent_q.cell_iy) < GRID_SIDE)
			&& (32'(ent_q.cell_iz) < GRID_SIDE);
		read_row = AW'(32'(ent_q.cell_ix) * GRID_SIDE + 32'(ent_q.cell_iy));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == AW'(ROWS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (!q_empty) state_d = (q_entry.command == CMD_READ) ? ST_READ : ST_DIV;
			end
			ST_DIV:    if (step_q == 5'(WHOLE_W - 1)) state_d = ST_HIT;
			ST_HIT:    state_d = ST_RMW_RD;
			ST_RMW_RD: begin
				if (pair_ok) state_d = ST_RMW_WR;
				else if (pair_q == 2'd3) state_d = ST_DONE;
			end
			ST_RMW_WR: state_d = (pair_q == 2'd3) ? ST_DONE : ST_RMW_RD;
			ST_READ:   state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		pop      = 1'b0;
		clearing = 1'b0;
		done     = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = read_row;
		wr_en    = 1'b0;
		wr_addr  = pair_row;
		wr_data  = rd_q | zmask;
		unique case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
				wr_en    = 1'b1;
				wr_addr  = clr_q;
				wr_data  = '0;
			end
			ST_IDLE:   pop = ~q_empty;
			ST_RMW_RD: begin
				rd_en   = pair_ok;
				rd_addr = pair_row;
			end
			ST_RMW_WR: wr_en = 1'b1;
			ST_READ:   rd_en = in_range;
			ST_DONE:   done = 1'b1;
			default: ;
		endcase
	end

	assign result.was_read     = ent_q.command;
	assign result.occupied     = (ent_q.command == CMD_READ) && in_range
		&& rd_q[IW'(ent_q.cell_iz)];
	assign result.cells_marked = (ent_q.command == CMD_READ) ? 4'd0 : count_q;

	// memory ports
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			step_q  <= '0;
			pair_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_DIV) step_q <= step_q + 1'b1;
			else step_q <= '0;
			if (state_q == ST_HIT) pair_q <= '0;
			else if ((state_q == ST_RMW_RD && !pair_ok) || state_q == ST_RMW_WR)
				pair_q <= pair_q + 1'b1;
		end
	end

	// datapath: entry capture, division lanes, hit lists
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_entry;
			for (int a = 0; a < 3; a++) begin
				num_q[a] <= q_entry.axis[a].whole;
				rem_q[a] <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			for (int a = 0; a < 3; a++) begin
				rem_q[a] <= ge[a] ? CSIZE_W'(sh[a] - {1'b0, divisor}) : sh[a][CSIZE_W-1:0];
				num_q[a] <= {num_q[a][WHOLE_W-2:0], ge[a]};
			end
		end
		if (state_q == ST_HIT) begin
			for (int a = 0; a < 3; a++) begin
				hv_q[a][0] <= hit_lo[a];
				hv_q[a][1] <= hit_hi[a];
				hi_q[a][0] <= IW'(num_q[a] - 1'b1);
				hi_q[a][1] <= IW'(num_q[a]);
			end
			count_q <= 4'(nhit[0]) * 4'(nhit[1]) * 4'(nhit[2]);
		end
	end

endmodule
